// ===== hw/rtl/tpmi_pkg.sv =====
// ----------------------------------------------------------------------------
// tpmi_pkg: shared types and constants for T-pattern marker identification
// Coordinate width, candidate triple table, request payload types.
// ----------------------------------------------------------------------------
package tpmi_pkg;

    localparam int COORD_BITS   = 10;
    localparam int BLOB_COUNT   = 4;
    localparam int TRIPLE_COUNT = 12;
    localparam int IDX_BITS     = 2;
    localparam int TRI_BITS     = 4;
    localparam int INDEX_SUM    = 6;

    // Signed difference, products and squared lengths
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;      // one signed product
    localparam int SQ_BITS   = 2 * COORD_BITS + 1; // unsigned sum of two squares
    localparam int CROSS_BITS = PROD_BITS + 1;     // signed cross / dot
    localparam int CMAG_BITS = CROSS_BITS - 1;
    localparam int NUM_BITS  = 2 * CMAG_BITS;      // cross squared
    localparam int CMP_BITS  = NUM_BITS + SQ_BITS; // cross-multiplied term

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]   idx_t;
    typedef logic [TRI_BITS-1:0]   tri_t;

    typedef struct packed {
        coord_t blob0_x;
        coord_t blob0_y;
        coord_t blob1_x;
        coord_t blob1_y;
        coord_t blob2_x;
        coord_t blob2_y;
        coord_t blob3_x;
        coord_t blob3_y;
    } blobs_t;

    typedef struct packed {
        idx_t front_index;
        idx_t left_index;
        idx_t middle_index;
        idx_t right_index;
    } roles_t;

    typedef struct packed {
        idx_t m;
        idx_t p;
        idx_t q;
        idx_t f;
    } triple_t;

    // middle, segment end P, segment end Q, front
    function automatic triple_t triple_of(input tri_t k);
        triple_t t;
        unique case (k)
            4'd0:    t = '{2'd2, 2'd0, 2'd1, 2'd3};
            4'd1:    t = '{2'd3, 2'd0, 2'd1, 2'd2};
            4'd2:    t = '{2'd1, 2'd0, 2'd2, 2'd3};
            4'd3:    t = '{2'd3, 2'd0, 2'd2, 2'd1};
            4'd4:    t = '{2'd1, 2'd0, 2'd3, 2'd2};
            4'd5:    t = '{2'd2, 2'd0, 2'd3, 2'd1};
            4'd6:    t = '{2'd0, 2'd1, 2'd2, 2'd3};
            4'd7:    t = '{2'd3, 2'd1, 2'd2, 2'd0};
            4'd8:    t = '{2'd0, 2'd1, 2'd3, 2'd2};
            4'd9:    t = '{2'd2, 2'd1, 2'd3, 2'd0};
            4'd10:   t = '{2'd0, 2'd2, 2'd3, 2'd1};
            4'd11:   t = '{2'd1, 2'd2, 2'd3, 2'd0};
            default: t = '{2'd2, 2'd0, 2'd1, 2'd3};
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/tpmi_if.sv =====
// ----------------------------------------------------------------------------
// tpmi_blob_if / tpmi_role_if: valid/ready request channels
// Blob coordinate channel in, marker role channel out.
// ----------------------------------------------------------------------------
interface tpmi_blob_if;
    import tpmi_pkg::*;
    logic   valid;
    logic   ready;
    blobs_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tpmi_role_if;
    import tpmi_pkg::*;
    logic   valid;
    logic   ready;
    roles_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/t_pattern_marker_identify.sv =====
// ----------------------------------------------------------------------------
// t_pattern_marker_identify: T-pattern marker role assignment
// Names front, left, middle and right among four tracked blobs.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                    handshake
//  blobs     in   blob0_x..blob3_y, COORD_BITS each          valid/ready
//  roles     out  front/left/middle/right index, 2b each     valid/ready
//
//  One request per cycle sustained while roles.ready is high; stages are S1
//  differences, S2 products, S3 dot/len/cross with clamp choice, S4 numerator
//  square, S5..S8 winner tree 12->6->3->2->1, S9 side decision into output reg.
//  All twelve triples run in parallel lanes; each tree level is one
//  registered cross-multiply compare, ties keep the lower triple index.
//  Reset clears only the stage valid bits. A stall freezes every full stage
//  whose later stages are all full; bubbles are squeezed out (a stage loads
//  when it is empty or when the one after it is empty or moving).
// ----------------------------------------------------------------------------
module t_pattern_marker_identify (
    input  logic        clk,
    input  logic        rst_n,
    tpmi_blob_if.sink   blobs,
    tpmi_role_if.source roles
);
    import tpmi_pkg::*;

    localparam int NS = 9;
    localparam int W5 = TRIPLE_COUNT / 2;   // 6 after first tree level
    localparam int W6 = W5 / 2;             // 3 after second level
    localparam int W7 = 2;                  // pair winner plus pass-through

    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;
    typedef logic [SQ_BITS-1:0]           sq_t;
    typedef logic [NUM_BITS-1:0]          num_t;
    typedef logic [CMP_BITS-1:0]          cmp_t;

    // na/da strictly below nb/db; dens are always positive
    function automatic logic dist_less(input num_t na, input sq_t da,
                                       input num_t nb, input sq_t db);
        return (cmp_t'(na) * cmp_t'(db)) < (cmp_t'(nb) * cmp_t'(da));
    endfunction

    // stage valid and advance
    logic [NS-1:0] v_reg;
    logic [NS-1:0] adv;

    always_comb
    begin
        adv[NS-1] = !v_reg[NS-1] || roles.ready;
        for (int s = NS - 2; s >= 0; s--)
            adv[s] = !v_reg[s] || adv[s+1];
    end

    assign blobs.ready = adv[0];
    assign roles.valid = v_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (adv[0])
                v_reg[0] <= blobs.valid;
            for (int s = 1; s < NS; s++)
                if (adv[s])
                    v_reg[s] <= v_reg[s-1];
        end
    end

    // ---------------- stage 0 input: coordinates
    coord_t cx_in [BLOB_COUNT];
    coord_t cy_in [BLOB_COUNT];
    assign cx_in[0] = blobs.data.blob0_x;
    assign cy_in[0] = blobs.data.blob0_y;
    assign cx_in[1] = blobs.data.blob1_x;
    assign cy_in[1] = blobs.data.blob1_y;
    assign cx_in[2] = blobs.data.blob2_x;
    assign cy_in[2] = blobs.data.blob2_y;
    assign cx_in[3] = blobs.data.blob3_x;
    assign cy_in[3] = blobs.data.blob3_y;

    // ---------------- S1: per-lane differences A=M-P, C=Q-P, B=M-Q
    diff_t ax_reg [TRIPLE_COUNT], ay_reg [TRIPLE_COUNT];
    diff_t cx_reg [TRIPLE_COUNT], cy_reg [TRIPLE_COUNT];
    diff_t bx_reg [TRIPLE_COUNT], by_reg [TRIPLE_COUNT];
    coord_t x1_reg [BLOB_COUNT], y1_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int k = 0; k < TRIPLE_COUNT; k++)
            begin
                automatic triple_t t = triple_of(TRI_BITS'(k));
                ax_reg[k] <= diff_t'({1'b0, cx_in[t.m]}) - diff_t'({1'b0, cx_in[t.p]});
                ay_reg[k] <= diff_t'({1'b0, cy_in[t.m]}) - diff_t'({1'b0, cy_in[t.p]});
                cx_reg[k] <= diff_t'({1'b0, cx_in[t.q]}) - diff_t'({1'b0, cx_in[t.p]});
                cy_reg[k] <= diff_t'({1'b0, cy_in[t.q]}) - diff_t'({1'b0, cy_in[t.p]});
                bx_reg[k] <= diff_t'({1'b0, cx_in[t.m]}) - diff_t'({1'b0, cx_in[t.q]});
                by_reg[k] <= diff_t'({1'b0, cy_in[t.m]}) - diff_t'({1'b0, cy_in[t.q]});
            end
            for (int b = 0; b < BLOB_COUNT; b++)
            begin
                x1_reg[b] <= cx_in[b];
                y1_reg[b] <= cy_in[b];
            end
        end
    end

    // ---------------- S2: products
    prod_t aa_x_reg [TRIPLE_COUNT], aa_y_reg [TRIPLE_COUNT];
    prod_t bb_x_reg [TRIPLE_COUNT], bb_y_reg [TRIPLE_COUNT];
    prod_t cc_x_reg [TRIPLE_COUNT], cc_y_reg [TRIPLE_COUNT];
    prod_t ac_x_reg [TRIPLE_COUNT], ac_y_reg [TRIPLE_COUNT];
    prod_t cr_a_reg [TRIPLE_COUNT], cr_b_reg [TRIPLE_COUNT];
    coord_t x2_reg [BLOB_COUNT], y2_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int k = 0; k < TRIPLE_COUNT; k++)
            begin
                aa_x_reg[k] <= ax_reg[k] * ax_reg[k];
                aa_y_reg[k] <= ay_reg[k] * ay_reg[k];
                bb_x_reg[k] <= bx_reg[k] * bx_reg[k];
                bb_y_reg[k] <= by_reg[k] * by_reg[k];
                cc_x_reg[k] <= cx_reg[k] * cx_reg[k];
                cc_y_reg[k] <= cy_reg[k] * cy_reg[k];
                ac_x_reg[k] <= ax_reg[k] * cx_reg[k];
                ac_y_reg[k] <= ay_reg[k] * cy_reg[k];
                cr_a_reg[k] <= ax_reg[k] * cy_reg[k];
                cr_b_reg[k] <= ay_reg[k] * cx_reg[k];
            end
            x2_reg <= x1_reg;
            y2_reg <= y1_reg;
        end
    end

    // ---------------- S3: dot, len, cross; pick clamp case
    // Distance kept as num/den: endpoint cases use den = 1.
    logic [TRIPLE_COUNT-1:0] seg_reg;      // interior case (num = cross^2)
    sq_t  pt_reg  [TRIPLE_COUNT];          // endpoint squared distance
    sq_t  len_reg [TRIPLE_COUNT];
    logic [CMAG_BITS-1:0] cmag_reg [TRIPLE_COUNT];
    coord_t x3_reg [BLOB_COUNT], y3_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int k = 0; k < TRIPLE_COUNT; k++)
            begin
                automatic cross_t dot = cross_t'(ac_x_reg[k]) + cross_t'(ac_y_reg[k]);
                automatic sq_t    len = SQ_BITS'(cc_x_reg[k]) + SQ_BITS'(cc_y_reg[k]);
                automatic cross_t cr  = cross_t'(cr_a_reg[k]) - cross_t'(cr_b_reg[k]);
                automatic logic   near_p = (len == '0) || dot[CROSS_BITS-1];
                automatic logic   far_q  = !near_p
                    && (dot > cross_t'({1'b0, len}));
                seg_reg[k] <= !near_p && !far_q;
                pt_reg[k]  <= near_p
                    ? SQ_BITS'(aa_x_reg[k]) + SQ_BITS'(aa_y_reg[k])
                    : SQ_BITS'(bb_x_reg[k]) + SQ_BITS'(bb_y_reg[k]);
                len_reg[k] <= len;
                cmag_reg[k] <= cr[CROSS_BITS-1] ? CMAG_BITS'(-cr) : CMAG_BITS'(cr);
            end
            x3_reg <= x2_reg;
            y3_reg <= y2_reg;
        end
    end

    // ---------------- S4: numerator and denominator per lane
    num_t num_reg [TRIPLE_COUNT];
    sq_t  den_reg [TRIPLE_COUNT];
    coord_t x4_reg [BLOB_COUNT], y4_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int k = 0; k < TRIPLE_COUNT; k++)
            begin
                num_reg[k] <= seg_reg[k] ? num_t'(cmag_reg[k]) * num_t'(cmag_reg[k])
                                         : num_t'(pt_reg[k]);
                den_reg[k] <= seg_reg[k] ? len_reg[k] : sq_t'(1);
            end
            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
        end
    end

    // ---------------- S5: tree level 12 -> 6
    // Later entry wins a pair only when strictly smaller.
    num_t n5_reg [W5];
    sq_t  d5_reg [W5];
    tri_t i5_reg [W5];
    coord_t x5_reg [BLOB_COUNT], y5_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            for (int k = 0; k < W5; k++)
            begin
                if (dist_less(num_reg[2*k+1], den_reg[2*k+1], num_reg[2*k], den_reg[2*k]))
                begin
                    n5_reg[k] <= num_reg[2*k+1];
                    d5_reg[k] <= den_reg[2*k+1];
                    i5_reg[k] <= TRI_BITS'(2 * k + 1);
                end
                else
                begin
                    n5_reg[k] <= num_reg[2*k];
                    d5_reg[k] <= den_reg[2*k];
                    i5_reg[k] <= TRI_BITS'(2 * k);
                end
            end
            x5_reg <= x4_reg;
            y5_reg <= y4_reg;
        end
    end

    // ---------------- S6: tree level 6 -> 3
    num_t n6_reg [W6];
    sq_t  d6_reg [W6];
    tri_t i6_reg [W6];
    coord_t x6_reg [BLOB_COUNT], y6_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            for (int k = 0; k < W6; k++)
            begin
                if (dist_less(n5_reg[2*k+1], d5_reg[2*k+1], n5_reg[2*k], d5_reg[2*k]))
                begin
                    n6_reg[k] <= n5_reg[2*k+1];
                    d6_reg[k] <= d5_reg[2*k+1];
                    i6_reg[k] <= i5_reg[2*k+1];
                end
                else
                begin
                    n6_reg[k] <= n5_reg[2*k];
                    d6_reg[k] <= d5_reg[2*k];
                    i6_reg[k] <= i5_reg[2*k];
                end
            end
            x6_reg <= x5_reg;
            y6_reg <= y5_reg;
        end
    end

    // ---------------- S7: tree level 3 -> 2 (last entry passes through)
    num_t n7_reg [W7];
    sq_t  d7_reg [W7];
    tri_t i7_reg [W7];
    coord_t x7_reg [BLOB_COUNT], y7_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            if (dist_less(n6_reg[1], d6_reg[1], n6_reg[0], d6_reg[0]))
            begin
                n7_reg[0] <= n6_reg[1];
                d7_reg[0] <= d6_reg[1];
                i7_reg[0] <= i6_reg[1];
            end
            else
            begin
                n7_reg[0] <= n6_reg[0];
                d7_reg[0] <= d6_reg[0];
                i7_reg[0] <= i6_reg[0];
            end
            n7_reg[1] <= n6_reg[2];
            d7_reg[1] <= d6_reg[2];
            i7_reg[1] <= i6_reg[2];
            x7_reg <= x6_reg;
            y7_reg <= y6_reg;
        end
    end

    // ---------------- S8: final tree level
    tri_t   i8_reg;
    coord_t x8_reg [BLOB_COUNT], y8_reg [BLOB_COUNT];

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            i8_reg <= dist_less(n7_reg[1], d7_reg[1], n7_reg[0], d7_reg[0])
                      ? i7_reg[1] : i7_reg[0];
            x8_reg <= x7_reg;
            y8_reg <= y7_reg;
        end
    end

    // ---------------- S9: side decision
    roles_t roles_next;

    always_comb
    begin
        triple_t t;
        diff_t pxm, pym, fxm, fym;
        prod_t pf, pg;
        logic signed [CROSS_BITS:0] sd;
        idx_t other;
        t = triple_of(i8_reg);
        pxm = diff_t'({1'b0, x8_reg[t.p]}) - diff_t'({1'b0, x8_reg[t.m]});
        pym = diff_t'({1'b0, y8_reg[t.p]}) - diff_t'({1'b0, y8_reg[t.m]});
        fxm = diff_t'({1'b0, x8_reg[t.f]}) - diff_t'({1'b0, x8_reg[t.m]});
        fym = diff_t'({1'b0, y8_reg[t.f]}) - diff_t'({1'b0, y8_reg[t.m]});
        pf = pxm * fym;
        pg = pym * fxm;
        sd = (CROSS_BITS+1)'(pf) - (CROSS_BITS+1)'(pg);
        other = IDX_BITS'(INDEX_SUM - int'(t.m) - int'(t.p) - int'(t.f));
        roles_next.front_index  = t.f;
        roles_next.middle_index = t.m;
        roles_next.left_index   = sd[CROSS_BITS] ? t.p : other;
        roles_next.right_index  = sd[CROSS_BITS] ? other : t.p;
    end

    roles_t roles_reg;
    always_ff @(posedge clk)
    begin
        if (adv[8])
            roles_reg <= roles_next;
    end
    assign roles.data = roles_reg;

endmodule

// ===== hw/rtl/tpmi_checker.sv =====
// ----------------------------------------------------------------------------
// tpmi_checker: port-level checks for t_pattern_marker_identify
// Role outputs form a permutation; output channel behaves under stall.
// ----------------------------------------------------------------------------
module tpmi_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          in_valid,
    input logic          in_ready,
    input logic          out_valid,
    input logic          out_ready,
    input tpmi_pkg::roles_t out_data
);
    import tpmi_pkg::*;

    logic [3:0] seen;
    assign seen = (4'b1 << out_data.front_index) | (4'b1 << out_data.left_index)
                | (4'b1 << out_data.middle_index) | (4'b1 << out_data.right_index);

    a_perm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen == 4'hF) else $error("roles not a permutation");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped under stall");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready) else $error("input blocked with empty output");

    // a fresh result follows an accepted request through the pipeline
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 9) || $past(out_valid))
        else $error("result without request");

endmodule

bind t_pattern_marker_identify tpmi_checker u_tpmi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (blobs.valid),
    .in_ready  (blobs.ready),
    .out_valid (roles.valid),
    .out_ready (roles.ready),
    .out_data  (roles.data)
);
